>>> hdl/storage_page_validator_defines.svh
// Assertion helpers shared by the validator modules.
`ifndef STORAGE_PAGE_VALIDATOR_DEFINES_SVH
`define STORAGE_PAGE_VALIDATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SPV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/spv_pkg.sv
`default_nettype none
package spv_pkg;

   localparam int MaxPageBytesDefault = 65536;
   localparam int PageSizeWidth = 17;
   localparam int ChunkWidth = 17;
   localparam int CsrAddrWidth = 3;
   localparam int EntryHdrBytes = 48;
   localparam int EntryCrcSpan = 44;
   localparam int SuperCrcSpan = 28;
   localparam int QueueDepth = 4;

   localparam logic [PageSizeWidth-1:0] PageSizeReset = 17'd4096;
   localparam logic [CsrAddrWidth-1:0] CsrPageSizeAddr = 3'd0;
   localparam logic [63:0] EntryMagic = 64'h004B_4253_454E_5452;
   localparam logic [63:0] SuperMagic = 64'h004B_4253_5355_5042;
   localparam logic [31:0] FormatVersion = 32'd1;
   localparam logic [31:0] Crc32cPoly = 32'h82F6_3B78;

   typedef enum logic [2:0] {
      STATUS_ENTRY_OK     = 3'd0,
      STATUS_SUPER_OK     = 3'd1,
      STATUS_BAD_LENGTH   = 3'd2,
      STATUS_BAD_MAGIC    = 3'd3,
      STATUS_BAD_GEOMETRY = 3'd4,
      STATUS_BAD_CRC      = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      GEOM_IDLE,
      GEOM_COUNT,
      GEOM_INDEX,
      GEOM_FINISH
   } geom_state_type;

   typedef struct packed {
      logic [7:0] page_byte;
      logic       superblock_page;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic        all_zero;
      logic [63:0] sequence_res;
      logic [63:0] key_or_bound;
      logic [63:0] payload_bytes;
      logic [31:0] chunk_number;
      logic [31:0] chunk_total;
      logic [15:0] chunk_bytes;
   } rsp_type;

   typedef struct packed {
      logic                     start;
      logic                     size_ok;
      logic [PageSizeWidth-1:0] page_size;
      logic [63:0]              payload;
      logic [31:0]              idx;
      logic [31:0]              cnt;
   } geom_req_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic                  ok;
      logic [ChunkWidth-1:0] chunk;
   } geom_result_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ Crc32cPoly) : (r >> 1);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> hdl/storage_page_validator.sv
// A last beat that reaches an empty queue is registered in the queue and then in the
// output register before its result is offered. Throughput: one page byte per cycle,
// pausing after header byte 47 of each entry page while the multiplier checks the geometry.
// A result waiting in the output register stalls only the next page's last byte.
// Reset: synchronous; clears queue, position, CRC and verdict state, page_size to 4096.
`default_nettype none
module storage_page_validator #(
   parameter int MAX_PAGE_BYTES = spv_pkg::MaxPageBytesDefault
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire spv_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output spv_pkg::rsp_type                       rsp_data,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [spv_pkg::CsrAddrWidth-1:0]  paddr,
   input  wire logic [31:0]                       pwdata,
   output logic [31:0]                            prdata,
   output logic                                   pready
);
   import spv_pkg::*;

   localparam int PosWidth = $clog2(MAX_PAGE_BYTES + 2);
   localparam int QWidth = PosWidth + $bits(req_type);

   logic [PageSizeWidth-1:0] page_size_ff, page_size_in;
   logic                     push, queue_full, pop, head_valid;
   logic [QWidth-1:0]        push_data, head_data;

   always_comb begin
      pready       = 1'b1;
      prdata       = (paddr == CsrPageSizeAddr) ? 32'(page_size_ff) : 32'd0;
      page_size_in = page_size_ff;
      if (psel && penable && pwrite && pready && (paddr == CsrPageSizeAddr)) begin
         page_size_in = pwdata[PageSizeWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_size_ff <= PageSizeReset;
      end else begin
         page_size_ff <= page_size_in;
      end
   end

   spv_front #(
      .MaxPageBytes (MAX_PAGE_BYTES),
      .PosWidth     (PosWidth)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   spv_queue #(
      .Width (QWidth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   spv_back #(
      .MaxPageBytes (MAX_PAGE_BYTES),
      .PosWidth     (PosWidth)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .page_size  (page_size_ff),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

>>> hdl/spv_queue.sv
`default_nettype none
module spv_queue #(
   parameter int Width = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [Width-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  head_valid,
   output logic [Width-1:0]      head_data
);
   import spv_pkg::*;
   `include "storage_page_validator_defines.svh"

   localparam int PtrWidth = $clog2(QueueDepth);
   localparam int CntWidth = $clog2(QueueDepth + 1);

   logic [Width-1:0]    mem_ff [QueueDepth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;

   always_comb begin
      full       = (count_ff == CntWidth'(QueueDepth));
      head_valid = (count_ff != '0);
      head_data  = mem_ff[rd_ptr_ff];
      wr_ptr_in  = push ? PtrWidth'((32'(wr_ptr_ff) + 1) % QueueDepth) : wr_ptr_ff;
      rd_ptr_in  = pop ? PtrWidth'((32'(rd_ptr_ff) + 1) % QueueDepth) : rd_ptr_ff;
      count_in   = count_ff + CntWidth'(push) - CntWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `SPV_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CntWidth'(QueueDepth), "queue count overflow")
   `SPV_ASSERT_NOW(a_pop_nonempty, clock, reset, pop, count_ff != '0, "pop from empty queue")
   `SPV_ASSERT_NEXT(a_push_grows, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1, "push lost")

endmodule
`default_nettype wire

>>> hdl/spv_front.sv
`default_nettype none
module spv_front #(
   parameter int MaxPageBytes = spv_pkg::MaxPageBytesDefault,
   parameter int PosWidth = $clog2(MaxPageBytes + 2)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire spv_pkg::req_type          req_data,
   input  wire logic                      queue_full,
   output logic                           push,
   output logic [PosWidth+$bits(spv_pkg::req_type)-1:0] push_data
);
   import spv_pkg::*;

   logic [PosWidth-1:0] pos_ff, pos_in;

   always_comb begin
      req_ready = !queue_full;
      push      = req_valid && req_ready;
      push_data = {pos_ff, req_data};
      pos_in    = pos_ff;
      if (push) begin
         if (req_data.last_byte) begin
            pos_in = '0;
         end else if (32'(pos_ff) <= MaxPageBytes) begin
            // saturate past the largest page
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule
`default_nettype wire

>>> hdl/spv_geom.sv
`default_nettype none
module spv_geom (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire spv_pkg::geom_req_type    req,
   output spv_pkg::geom_result_type      result
);
   import spv_pkg::*;

   geom_state_type              state_ff, state_in;
   logic [48:0]                 prod_ff, prod_in;
   logic                        le_ok_ff, le_ok_in, gt_ok_ff, gt_ok_in;
   logic [PageSizeWidth-1:0]    cap;
   logic [63:0]                 diff;
   logic                        ok;

   always_comb begin
      cap      = req.page_size - PageSizeWidth'(EntryHdrBytes);
      diff     = req.payload - 64'(prod_ff);
      state_in = state_ff;
      prod_in  = prod_ff;
      le_ok_in = le_ok_ff;
      gt_ok_in = gt_ok_ff;
      ok       = 1'b0;
      result   = '0;
      result.busy = (state_ff != GEOM_IDLE);
      unique case (state_ff)
         GEOM_IDLE: begin
            if (req.start) begin
               state_in = GEOM_COUNT;
            end
         end
         GEOM_COUNT: begin
            prod_in  = 49'(req.cnt) * 49'(cap);
            state_in = GEOM_INDEX;
         end
         GEOM_INDEX: begin
            // count matches ceil(payload / cap) with a floor of one
            le_ok_in = req.payload <= 64'(prod_ff);
            gt_ok_in = (req.cnt == 32'd1) || (req.payload > 64'(prod_ff - 49'(cap)));
            prod_in  = 49'(req.idx) * 49'(cap);
            state_in = GEOM_FINISH;
         end
         GEOM_FINISH: begin
            ok = req.size_ok && (req.idx < req.cnt) && le_ok_ff && gt_ok_ff;
            result.done = 1'b1;
            result.ok   = ok;
            if (ok) begin
               result.chunk = ((33'(req.idx) + 33'd1) < 33'(req.cnt)) ? cap
                                                                      : diff[ChunkWidth-1:0];
            end
            state_in = GEOM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= GEOM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      le_ok_ff <= le_ok_in;
      gt_ok_ff <= gt_ok_in;
   end

endmodule
`default_nettype wire

>>> hdl/spv_back.sv
`default_nettype none
module spv_back #(
   parameter int MaxPageBytes = spv_pkg::MaxPageBytesDefault,
   parameter int PosWidth = $clog2(MaxPageBytes + 2)
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [spv_pkg::PageSizeWidth-1:0]     page_size,
   input  wire logic                                  head_valid,
   input  wire logic [PosWidth+$bits(spv_pkg::req_type)-1:0] head_data,
   output logic                                       pop,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output spv_pkg::rsp_type                           rsp_data
);
   import spv_pkg::*;
   `include "storage_page_validator_defines.svh"

   localparam int ReqWidth = $bits(req_type);

   logic [7:0]            hdr_ff [EntryHdrBytes];
   logic                  kind_ff, kind_in;
   logic                  nz_ff, nz_in;
   logic [31:0]           crc_ff, crc_in;
   logic [ChunkWidth-1:0] exp_ff, exp_in;
   logic                  geo_ok_ff, geo_ok_in;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_data_ff, out_data_in;

   req_type               beat;
   logic [PosWidth-1:0]   pos;
   logic                  out_free, size_ok, len_ok, crc_en;
   logic [31:0]           crc_next;
   logic [63:0]           magic, seq, key, payload;
   logic [31:0]           ent_ver, idx, cnt, ent_crc, sb_ver, sb_crc;
   status_type            status;
   geom_req_type          geom_req;
   geom_result_type       geom_res;

   spv_geom u_geom (
      .clock  (clock),
      .reset  (reset),
      .req    (geom_req),
      .result (geom_res)
   );

   always_comb begin
      beat = req_type'(head_data[ReqWidth-1:0]);
      pos  = head_data[PosWidth+ReqWidth-1 -: PosWidth];
      for (int i = 0; i < 8; i++) begin
         magic[8*i +: 8]   = hdr_ff[i];
         seq[8*i +: 8]     = hdr_ff[8 + i];
         key[8*i +: 8]     = hdr_ff[16 + i];
         payload[8*i +: 8] = hdr_ff[24 + i];
      end
      for (int i = 0; i < 4; i++) begin
         sb_ver[8*i +: 8]  = hdr_ff[24 + i];
         sb_crc[8*i +: 8]  = hdr_ff[28 + i];
         ent_ver[8*i +: 8] = hdr_ff[32 + i];
         idx[8*i +: 8]     = hdr_ff[36 + i];
         cnt[8*i +: 8]     = hdr_ff[40 + i];
         ent_crc[8*i +: 8] = hdr_ff[44 + i];
      end

      size_ok  = (page_size >= PageSizeWidth'(EntryHdrBytes + 1))
                 && (32'(page_size) <= MaxPageBytes);
      out_free = !out_valid_ff || rsp_ready;
      // hold the head while geometry runs or the last beat has no slot
      pop      = head_valid && !geom_res.busy && (!beat.last_byte || out_free);

      kind_in = (pos == '0) ? beat.superblock_page : kind_ff;
      nz_in   = nz_ff || (beat.page_byte != 8'd0);
      if (kind_in) begin
         crc_en = 32'(pos) < SuperCrcSpan;
      end else begin
         crc_en = (32'(pos) < EntryCrcSpan)
                  || ((32'(pos) >= EntryHdrBytes)
                      && ((32'(pos) - EntryHdrBytes) < 32'(exp_ff)));
      end
      crc_next = crc_en ? crc_byte(crc_ff, beat.page_byte) : crc_ff;

      geom_req.start     = pop && !kind_in && (32'(pos) == EntryHdrBytes - 1)
                           && !beat.last_byte;
      geom_req.size_ok   = size_ok;
      geom_req.page_size = page_size;
      geom_req.payload   = payload;
      geom_req.idx       = idx;
      geom_req.cnt       = cnt;

      len_ok = size_ok && ((32'(pos) + 32'd1) == 32'(page_size));
      if (!len_ok) begin
         status = STATUS_BAD_LENGTH;
      end else if (kind_in) begin
         priority if (magic != SuperMagic || sb_ver != FormatVersion) status = STATUS_BAD_MAGIC;
         else if (sb_crc != ~crc_next) status = STATUS_BAD_CRC;
         else status = STATUS_SUPER_OK;
      end else begin
         priority if (magic != EntryMagic || ent_ver != FormatVersion) status = STATUS_BAD_MAGIC;
         else if (!geo_ok_ff) status = STATUS_BAD_GEOMETRY;
         else if (ent_crc != ~crc_next) status = STATUS_BAD_CRC;
         else status = STATUS_ENTRY_OK;
      end

      out_data_in = '0;
      out_data_in.status = status;
      if (len_ok) begin
         out_data_in.all_zero     = !nz_in;
         out_data_in.sequence_res = seq;
         out_data_in.key_or_bound = key;
         if (!kind_in) begin
            out_data_in.payload_bytes = payload;
            out_data_in.chunk_number  = idx;
            out_data_in.chunk_total   = cnt;
            if (status == STATUS_ENTRY_OK || status == STATUS_BAD_CRC) begin
               out_data_in.chunk_bytes = exp_ff[15:0];
            end
         end
      end

      out_valid_in = (pop && beat.last_byte) ? 1'b1 : (out_valid_ff && !rsp_ready);

      crc_in    = crc_ff;
      exp_in    = exp_ff;
      geo_ok_in = geo_ok_ff;
      if (geom_res.done) begin
         exp_in    = geom_res.chunk;
         geo_ok_in = geom_res.ok;
      end
      if (pop) begin
         crc_in = crc_next;
         if (beat.last_byte) begin
            // clear per-page state
            kind_in = 1'b0;
            nz_in   = 1'b0;
            crc_in  = '1;
            exp_in  = '0;
         end
      end else begin
         kind_in = kind_ff;
         nz_in   = nz_ff;
      end

      rsp_valid = out_valid_ff;
      rsp_data  = out_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff      <= 1'b0;
         nz_ff        <= 1'b0;
         crc_ff       <= '1;
         exp_ff       <= '0;
         geo_ok_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         kind_ff      <= kind_in;
         nz_ff        <= nz_in;
         crc_ff       <= crc_in;
         exp_ff       <= exp_in;
         geo_ok_ff    <= geo_ok_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && beat.last_byte) begin
         out_data_ff <= out_data_in;
      end
      if (pop && (32'(pos) < EntryHdrBytes)) begin
         hdr_ff[pos[5:0]] <= beat.page_byte;
      end
   end

   `SPV_ASSERT_NOW(a_result_from_last, clock, reset, $rose(out_valid_ff), $past(pop && beat.last_byte), "result without last beat")
   `SPV_ASSERT_NEXT(a_geom_starts, clock, reset, geom_req.start, geom_res.busy, "geometry did not start")
   `SPV_ASSERT_NOW(a_crc_fresh, clock, reset, pop && (pos == '0), crc_ff == 32'hFFFF_FFFF, "crc not cleared at page start")

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
`default_nettype none
module tb_top;
   import spv_pkg::*;

   localparam int MaxBytes = MaxPageBytesDefault;
   localparam int SettleCycles = 12;
   localparam longint CycleLimit = 3_000_000;

   typedef enum {
      FORM_ENTRY_OK,
      FORM_SUPER_OK,
      FORM_BAD_MAGIC,
      FORM_BAD_VERSION,
      FORM_BAD_COUNT,
      FORM_BAD_INDEX,
      FORM_BAD_CRC,
      FORM_ZERO,
      FORM_NOISE
   } page_form_type;

   typedef struct {
      page_form_type form;
      bit            sb;
      int            delta;
      bit            typed;
      status_type    st;
   } page_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   // shadow of the block's page state
   logic [16:0] size_reg = PageSizeReset;
   int unsigned pos = 0;
   logic [7:0] hdr [48];
   logic [31:0] crc_acc = '1;
   bit seen_nonzero = 1'b0;
   bit super_kind = 1'b0;
   logic [31:0] chunk_len = '0;

   rsp_type verdict_q[$];
   rsp_type verdict_want;
   logic [7:0] page_bytes[$];
   bit req_fire = 1'b0;
   bit rsp_fire = 1'b0;
   rsp_type rsp_seen;
   bit typed_on = 1'b0;
   status_type typed_status = STATUS_ENTRY_OK;
   int idle_pct = 22;
   int errors = 0;
   int pages_sent = 0;
   int verdicts_checked = 0;
   int bytes_sent = 0;
   longint cycles = 0;

   page_row_type plan[] = '{
      '{FORM_ENTRY_OK, 1'b0, -4047, 1'b1, STATUS_BAD_LENGTH},
      '{FORM_ENTRY_OK, 1'b0, 0, 1'b0, STATUS_ENTRY_OK},
      '{FORM_SUPER_OK, 1'b1, 0, 1'b1, STATUS_SUPER_OK},
      '{FORM_BAD_MAGIC, 1'b0, 0, 1'b1, STATUS_BAD_MAGIC},
      '{FORM_BAD_MAGIC, 1'b1, 0, 1'b1, STATUS_BAD_MAGIC},
      '{FORM_BAD_VERSION, 1'b0, 0, 1'b1, STATUS_BAD_MAGIC},
      '{FORM_BAD_VERSION, 1'b1, 0, 1'b1, STATUS_BAD_MAGIC},
      '{FORM_BAD_COUNT, 1'b0, 0, 1'b1, STATUS_BAD_GEOMETRY},
      '{FORM_BAD_INDEX, 1'b0, 0, 1'b1, STATUS_BAD_GEOMETRY},
      '{FORM_BAD_CRC, 1'b0, 0, 1'b1, STATUS_BAD_CRC},
      '{FORM_BAD_CRC, 1'b1, 0, 1'b1, STATUS_BAD_CRC},
      '{FORM_ZERO, 1'b0, 0, 1'b1, STATUS_BAD_MAGIC},
      '{FORM_ZERO, 1'b1, 0, 1'b1, STATUS_BAD_MAGIC},
      '{FORM_ENTRY_OK, 1'b0, -1, 1'b1, STATUS_BAD_LENGTH},
      '{FORM_SUPER_OK, 1'b1, 1, 1'b1, STATUS_BAD_LENGTH},
      '{FORM_NOISE, 1'b0, 0, 1'b0, STATUS_ENTRY_OK},
      '{FORM_NOISE, 1'b1, 0, 1'b0, STATUS_ENTRY_OK}
   };

   storage_page_validator u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] crc32c_update(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ Crc32cPoly) : (r >> 1);
      end
      return r;
   endfunction

   function automatic logic [63:0] hdr_field(int at, int n);
      logic [63:0] v;
      v = '0;
      for (int i = 0; i < n; i++) begin
         v |= 64'(hdr[(at + i) % 48]) << (8 * i);
      end
      return v;
   endfunction

   function automatic bit size_in_range();
      return size_reg >= 17'd49 && 32'(size_reg) <= MaxBytes;
   endfunction

   function automatic bit chunk_geometry(output logic [63:0] chunk);
      logic [63:0] cap, pl, idx, cnt, need;
      chunk = '0;
      if (!size_in_range()) return 1'b0;
      cap = 64'(size_reg) - 64'd48;
      pl = hdr_field(24, 8);
      idx = hdr_field(36, 4);
      cnt = hdr_field(40, 4);
      need = pl / cap + ((pl % cap) != 0 ? 64'd1 : 64'd0);
      if (need == 0) need = 1;
      if (idx >= cnt || cnt != need) return 1'b0;
      chunk = (idx + 1 < cnt) ? cap : pl - cap * idx;
      return 1'b1;
   endfunction

   // Advance the shadow state by one byte; return 1 when a verdict is due.
   function automatic bit predict_verdict(req_type it, output rsp_type v);
      int unsigned p;
      logic [63:0] c;
      status_type st;
      p = pos;
      v = '0;
      if (p == 0) super_kind = it.superblock_page;
      if (p < 48) hdr[p] = it.page_byte;
      if (it.page_byte != 0) seen_nonzero = 1'b1;
      if (super_kind) begin
         if (p < SuperCrcSpan) crc_acc = crc32c_update(crc_acc, it.page_byte);
      end else begin
         if (p < EntryCrcSpan || (p >= 48 && p - 48 < chunk_len))
            crc_acc = crc32c_update(crc_acc, it.page_byte);
         if (p == 47) begin
            void'(chunk_geometry(c));
            chunk_len = c[31:0];
         end
      end
      if (!it.last_byte) begin
         if (p <= MaxBytes) pos = p + 1;
         return 1'b0;
      end
      if (!size_in_range() || p + 1 != 32'(size_reg)) begin
         st = STATUS_BAD_LENGTH;
      end else begin
         v.all_zero = !seen_nonzero;
         v.sequence_res = hdr_field(8, 8);
         v.key_or_bound = hdr_field(16, 8);
         if (super_kind) begin
            if (hdr_field(0, 8) != SuperMagic || hdr_field(24, 4) != 64'(FormatVersion))
               st = STATUS_BAD_MAGIC;
            else if (hdr_field(28, 4) != {32'd0, ~crc_acc})
               st = STATUS_BAD_CRC;
            else
               st = STATUS_SUPER_OK;
         end else begin
            v.payload_bytes = hdr_field(24, 8);
            v.chunk_number = hdr_field(36, 4);
            v.chunk_total = hdr_field(40, 4);
            if (hdr_field(0, 8) != EntryMagic || hdr_field(32, 4) != 64'(FormatVersion)) begin
               st = STATUS_BAD_MAGIC;
            end else if (!chunk_geometry(c)) begin
               st = STATUS_BAD_GEOMETRY;
            end else begin
               v.chunk_bytes = c[15:0];
               st = (hdr_field(44, 4) != {32'd0, ~crc_acc}) ? STATUS_BAD_CRC
                                                            : STATUS_ENTRY_OK;
            end
         end
      end
      v.status = st;
      pos = 0;
      crc_acc = '1;
      seen_nonzero = 1'b0;
      super_kind = 1'b0;
      chunk_len = '0;
      return 1'b1;
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         errors++;
         $error("%s expected %0h got %0h", name, want, got);
      end
   endtask

   // sample both handshakes mid-cycle, when everything is settled
   always @(negedge clock) begin
      req_fire = req_valid && req_ready;
      rsp_fire = rsp_valid && rsp_ready;
      rsp_seen = rsp_data;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("storage_page_validator verification failed");
         $finish;
      end else begin
         rsp_ready <= !reset && ($urandom_range(99) >= idle_pct);
         if (rsp_fire) begin
            if (verdict_q.size() == 0) begin
               errors++;
               $error("verdict beat with nothing expected");
            end else begin
               verdict_want = verdict_q.pop_front();
               verdicts_checked++;
               check_field("status", 64'(verdict_want.status), 64'(rsp_seen.status));
               check_field("all_zero", 64'(verdict_want.all_zero), 64'(rsp_seen.all_zero));
               check_field("sequence_res", verdict_want.sequence_res, rsp_seen.sequence_res);
               check_field("key_or_bound", verdict_want.key_or_bound, rsp_seen.key_or_bound);
               check_field("payload_bytes", verdict_want.payload_bytes,
                           rsp_seen.payload_bytes);
               check_field("chunk_number", 64'(verdict_want.chunk_number),
                           64'(rsp_seen.chunk_number));
               check_field("chunk_total", 64'(verdict_want.chunk_total),
                           64'(rsp_seen.chunk_total));
               check_field("chunk_bytes", 64'(verdict_want.chunk_bytes),
                           64'(rsp_seen.chunk_bytes));
            end
         end
      end
   end

   task automatic send_beat(req_type it);
      rsp_type v;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (!req_fire);
      bytes_sent++;
      if (predict_verdict(it, v)) begin
         if (typed_on) v.status = typed_status;
         verdict_q = {verdict_q, v};
      end
      // drop valid after the last byte so no stale beat lingers
      if (it.last_byte) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_page(bit sb);
      req_type it;
      for (int i = 0; i < page_bytes.size(); i++) begin
         it.page_byte = page_bytes[i];
         it.superblock_page = (i == 0) ? sb : 1'($urandom_range(1));
         it.last_byte = (i == page_bytes.size() - 1);
         send_beat(it);
      end
      pages_sent++;
   endtask

   task automatic put_le(int at, logic [63:0] v, int n);
      for (int i = 0; i < n; i++) page_bytes[at + i] = v[8*i +: 8];
   endtask

   task automatic build_page(page_form_type form, int len, bit sb);
      logic [63:0] cap, pl, idx, cnt, chunk;
      logic [31:0] c, ver;
      page_bytes.delete();
      for (int i = 0; i < len; i++)
         page_bytes = {page_bytes, (form == FORM_ZERO ? 8'd0 : 8'($urandom_range(255)))};
      if (form == FORM_ZERO || form == FORM_NOISE || len < 49) return;
      ver = FormatVersion;
      if (form == FORM_BAD_VERSION) begin
         ver = $urandom;
         if (ver == FormatVersion) ver = 32'd2;
      end
      put_le(0, sb ? SuperMagic : EntryMagic, 8);
      put_le(8, {$urandom, $urandom}, 8);
      put_le(16, {$urandom, $urandom}, 8);
      c = '1;
      if (sb) begin
         put_le(24, 64'(ver), 4);
         for (int i = 0; i < SuperCrcSpan; i++) c = crc32c_update(c, page_bytes[i]);
         put_le(28, 64'(~c), 4);
      end else begin
         cap = 64'(len - 48);
         cnt = ($urandom_range(3) == 0) ? 64'($urandom) : 64'($urandom_range(4, 1));
         if (cnt == 0) cnt = 1;
         idx = 64'($urandom) % cnt;
         if (cnt == 1 && $urandom_range(3) == 0) pl = 0;
         else pl = (cnt - 1) * cap + 64'($urandom_range(32'(cap), 1));
         chunk = (idx + 1 < cnt) ? cap : pl - cap * idx;
         if (form == FORM_BAD_COUNT) begin
            if ($urandom_range(1)) pl = {$urandom, $urandom};
            else cnt = cnt + 1;
         end
         if (form == FORM_BAD_INDEX) idx = cnt + 64'($urandom_range(3));
         put_le(24, pl, 8);
         put_le(32, 64'(ver), 4);
         put_le(36, idx, 4);
         put_le(40, cnt, 4);
         for (int i = 0; i < EntryCrcSpan; i++) c = crc32c_update(c, page_bytes[i]);
         for (int i = 48; i < 48 + int'(chunk) && i < len; i++)
            c = crc32c_update(c, page_bytes[i]);
         put_le(44, 64'(~c), 4);
      end
      if (form == FORM_BAD_MAGIC) page_bytes[$urandom_range(7)] ^= 8'(1 << $urandom_range(7));
      if (form == FORM_BAD_CRC)
         page_bytes[(sb ? 28 : 44) + $urandom_range(3)] ^= 8'(1 << $urandom_range(7));
   endtask

   task automatic wait_settled();
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // write page_size, then read it back in the following transfer
   task automatic write_page_size(logic [31:0] v);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= CsrPageSizeAddr;
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      size_reg = v[16:0];
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      check_field("page_size readback", 64'({15'd0, size_reg}), 64'(prdata));
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin
      int sizes[8];
      int sz, len, r;
      bit sb;
      page_form_type form;
      for (int i = 0; i < 48; i++) hdr[i] = '0;
      sizes = '{49, 64, 0, 48, 65537, 131071, 120, 56};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed pages: first a short page at the reset page size, the rest at page size 49
      foreach (plan[i]) begin
         if (i == 1) begin
            wait_settled();
            write_page_size(32'd49);
         end
         typed_on = plan[i].typed;
         typed_status = plan[i].st;
         build_page(plan[i].form, int'(size_reg) + plan[i].delta, plan[i].sb);
         send_page(plan[i].sb);
         typed_on = 1'b0;
      end
      // hold the sender until every verdict is back
      wait_settled();

      for (int ph = 0; ph < 8; ph++) begin
         sz = sizes[ph];
         wait_settled();
         write_page_size(32'(sz));
         idle_pct = (ph == 1) ? 0 : 22;
         repeat ((ph == 1) ? 2 : 1) begin
            r = $urandom_range(99);
            form = r < 45 ? FORM_ENTRY_OK : r < 65 ? FORM_SUPER_OK :
                   r < 70 ? FORM_BAD_MAGIC : r < 75 ? FORM_BAD_VERSION :
                   r < 80 ? FORM_BAD_COUNT : r < 85 ? FORM_BAD_INDEX :
                   r < 92 ? FORM_BAD_CRC : r < 95 ? FORM_ZERO : FORM_NOISE;
            sb = (form == FORM_SUPER_OK) ? 1'b1 :
                 (form == FORM_ENTRY_OK || form == FORM_BAD_COUNT ||
                  form == FORM_BAD_INDEX) ? 1'b0 : 1'($urandom_range(1));
            if (sz >= 49 && sz <= MaxBytes) begin
               len = ($urandom_range(99) < 85) ? sz : sz + $urandom_range(6) - 3;
               if (len < 1) len = 1;
            end else begin
               len = $urandom_range(40, 1);
            end
            build_page(form, len, sb);
            send_page(sb);
         end
      end
      idle_pct = 22;

      wait_settled();
      $display("Sent %0d pages (%0d bytes), checked %0d verdicts across page sizes",
               pages_sent, bytes_sent, verdicts_checked);
      $display("from 0 to 131071, including good, corrupt, zero and wrong-length pages.");
      if (errors == 0 && verdict_q.size() == 0) begin
         $display("storage_page_validator verification clean");
      end else begin
         $display("storage_page_validator verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> storage_page_validator.f
+incdir+hdl
hdl/spv_pkg.sv
hdl/spv_queue.sv
hdl/spv_front.sv
hdl/spv_geom.sv
hdl/spv_back.sv
hdl/storage_page_validator.sv
tb/sv/tb_top.sv
